// File: rtl/arcl_pkg.sv
// ----------------------------------------------------------------------------
// arcl_pkg: shared types for the row cluster legalizer
// controller command and status bundles, fixed field widths
// ----------------------------------------------------------------------------
package arcl_pkg;

  localparam int QW = 24;  // cluster q sum, signed
  localparam int WW = 16;  // positions, row width, cluster width sum
  localparam int EW = 9;   // padded cell width

  typedef struct packed {
    logic [15:0]   tag;
    logic [5:0]    pl;
    logic [EW-1:0] eff;
  } cell_t;

  typedef struct packed {
    logic accept;
    logic push;
    logic rd_pv;
    logic opt_m;
    logic mul_m;
    logic merge;
    logic k_clr;
    logic rd_k;
    logic e_ld;
    logic div_step;
    logic px_ld;
    logic emit;
    logic k_inc;
    logic row_clear;
  } cmd_t;

  typedef struct packed {
    logic push_ok;
    logic last;
    logic ge2;
    logic zero;
    logic merge_go;
    logic div_last;
    logic cell_last;
    logic k_last;
  } sts_t;

endpackage

// File: rtl/arcl_ctrl.sv
// ----------------------------------------------------------------------------
// arcl_ctrl: sequencer of the row cluster legalizer
// steps push, merge compare and row emission through the datapath
// ----------------------------------------------------------------------------
module arcl_ctrl import arcl_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic start,
  output logic busy,
  input  sts_t sts,
  output cmd_t cmd
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_DEC   = 4'd1;
  localparam logic [3:0] S_PUSH  = 4'd2;
  localparam logic [3:0] S_MRD   = 4'd3;
  localparam logic [3:0] S_MOPT  = 4'd4;
  localparam logic [3:0] S_MMUL  = 4'd5;
  localparam logic [3:0] S_MCMP  = 4'd6;
  localparam logic [3:0] S_FIN   = 4'd7;
  localparam logic [3:0] S_EK    = 4'd8;
  localparam logic [3:0] S_ELD   = 4'd9;
  localparam logic [3:0] S_EDIV  = 4'd10;
  localparam logic [3:0] S_EPX   = 4'd11;
  localparam logic [3:0] S_ECELL = 4'd12;
  localparam logic [3:0] S_CLR   = 4'd13;

  logic [3:0] state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign busy = (state != S_IDLE);

  always_comb begin
    state_next = state;
    cmd = '0;
    case (state)
      S_IDLE: begin
        if (start) begin
          cmd.accept = 1'b1;
          state_next = S_DEC;
        end
      end
      S_DEC: begin
        if (sts.push_ok) state_next = S_PUSH;
        else state_next = S_FIN;
      end
      S_PUSH: begin
        cmd.push = 1'b1;
        state_next = S_MRD;
      end
      S_MRD: begin
        if (sts.ge2) begin
          cmd.rd_pv = 1'b1;
          state_next = S_MOPT;
        end else begin
          state_next = S_FIN;
        end
      end
      S_MOPT: begin
        cmd.opt_m = 1'b1;
        state_next = S_MMUL;
      end
      S_MMUL: begin
        cmd.mul_m = 1'b1;
        state_next = S_MCMP;
      end
      S_MCMP: begin
        if (sts.merge_go) begin
          cmd.merge = 1'b1;
          state_next = S_MRD;
        end else begin
          state_next = S_FIN;
        end
      end
      S_FIN: begin
        cmd.k_clr = 1'b1;
        if (!sts.last) state_next = S_IDLE;
        else if (sts.zero) state_next = S_CLR;
        else state_next = S_EK;
      end
      S_EK: begin
        cmd.rd_k = 1'b1;
        state_next = S_ELD;
      end
      S_ELD: begin
        cmd.e_ld = 1'b1;
        state_next = S_EDIV;
      end
      S_EDIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_last) state_next = S_EPX;
      end
      S_EPX: begin
        cmd.px_ld = 1'b1;
        state_next = S_ECELL;
      end
      S_ECELL: begin
        cmd.emit = 1'b1;
        if (sts.cell_last) begin
          if (sts.k_last) begin
            state_next = S_CLR;
          end else begin
            cmd.k_inc = 1'b1;
            state_next = S_EK;
          end
        end
      end
      S_CLR: begin
        cmd.row_clear = 1'b1;
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

// File: rtl/arcl_dp.sv
// ----------------------------------------------------------------------------
// arcl_dp: datapath of the row cluster legalizer
// cluster stack, cell store, cross-multiply compare, rounding divider
// ----------------------------------------------------------------------------
module arcl_dp import arcl_pkg::*; #(
  parameter int MAX_CELLS_PER_ROW = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  cmd_t        cmd,
  output sts_t        sts,
  input  logic        cfg_we,
  input  logic [15:0] cfg_wdata,
  input  logic [15:0] cell_tag,
  input  logic [11:0] row_index,
  input  logic [15:0] target_x,
  input  logic [7:0]  cell_width,
  input  logic [5:0]  pad_left,
  input  logic [5:0]  pad_right,
  input  logic        skip_cell,
  input  logic        last_in_row,
  output logic        out_valid,
  output logic [15:0] out_tag,
  output logic [11:0] out_row,
  output logic [15:0] placed_x,
  output logic        last_result
);

  localparam int AW = $clog2(MAX_CELLS_PER_ROW);
  localparam int CW = $clog2(MAX_CELLS_PER_ROW + 1);
  localparam int LW = ((WW + CW > QW) ? WW + CW : QW) + 1;
  localparam int PW = QW + WW + CW;
  localparam int DW = QW + 2;
  localparam int NW = $clog2(DW);

  typedef struct packed {
    logic signed [QW-1:0] q;
    logic [CW-1:0]        c;
    logic [WW-1:0]        w;
  } clu_t;

  typedef struct packed {
    logic [QW-1:0]        num;
    logic [CW-1:0]        den;
    logic signed [WW:0]   hi;
  } opt_t;

  // clamped optimum as num / den
  function automatic opt_t opt_f(input clu_t cl, input logic [WW-1:0] rw);
    logic signed [WW:0] hi;
    logic [CW-1:0]      cc;
    logic [WW+CW-1:0]   lim;
    opt_t               o;
    hi  = $signed({1'b0, rw}) - $signed({1'b0, cl.w});
    cc  = (cl.c == '0) ? CW'(1) : cl.c;
    lim = (WW+CW)'(hi[WW-1:0]) * (WW+CW)'(cc);
    o.hi = hi;
    if (cl.q < 0 || hi < 0) begin
      o.num = '0;
      o.den = CW'(1);
    end else if (PW'(unsigned'(cl.q)) > PW'(lim)) begin
      o.num = QW'(hi[WW-1:0]);
      o.den = CW'(1);
    end else begin
      o.num = unsigned'(cl.q);
      o.den = cc;
    end
    return o;
  endfunction

  logic [WW-1:0] row_width;
  logic [15:0]   l_tag;
  logic [11:0]   l_row;
  logic [15:0]   l_tx;
  logic [7:0]    l_w;
  logic [5:0]    l_pl, l_pr;
  logic          l_skip, l_last;

  clu_t          cmem [MAX_CELLS_PER_ROW];
  cell_t         smem [MAX_CELLS_PER_ROW];
  clu_t          top, rd;
  cell_t         crd;
  logic [CW-1:0] depth, ncell, k, cptr, cptr_next, crem, dm1, dm2;
  logic [AW-1:0] rd_addr;

  logic [QW-1:0]     pn, ln;
  logic [CW-1:0]     pd, ld;
  logic [WW-1:0]     pw;
  logic [LW-1:0]     lhs_a;
  logic [QW+CW-1:0]  rhs;
  logic [LW+CW-1:0]  lhs;

  logic [DW-1:0]     dvd;
  logic [CW:0]       dvs, rem;
  logic [CW+1:0]     rsh;
  logic [NW-1:0]     dcnt;
  logic signed [WW:0] e_hi;
  logic [WW:0]       px;
  logic [WW+1:0]     xsum;
  logic [EW-1:0]     eff;
  clu_t              ecl;
  opt_t              eo, po, lo;

  assign dm1 = depth - CW'(1);
  assign dm2 = depth - CW'(2);
  assign rd_addr = cmd.rd_pv ? dm2[AW-1:0] : k[AW-1:0];
  assign eff = EW'(l_w) + EW'(l_pl) + EW'(l_pr);
  assign ecl = (k == dm1) ? top : rd;
  assign eo = opt_f(ecl, row_width);
  assign po = opt_f(rd, row_width);
  assign lo = opt_f(top, row_width);
  assign lhs = (LW+CW)'(lhs_a) * (LW+CW)'(ld);
  assign rsh = {rem, dvd[DW-1]};
  assign xsum = (WW+2)'(px) + (WW+2)'(crd.pl);

  always_comb begin
    cptr_next = cptr;
    if (cmd.row_clear) cptr_next = '0;
    else if (cmd.emit) cptr_next = cptr + CW'(1);
  end

  assign sts.push_ok   = !l_skip && (ncell < CW'(MAX_CELLS_PER_ROW));
  assign sts.last      = l_last;
  assign sts.ge2       = (depth >= CW'(2));
  assign sts.zero      = (depth == '0);
  assign sts.merge_go  = lhs > (LW+CW)'(rhs);
  assign sts.div_last  = (dcnt == NW'(DW - 1));
  assign sts.cell_last = (crem == CW'(1));
  assign sts.k_last    = (k == dm1);

  // control counters
  always_ff @(posedge clk) begin
    if (rst) begin
      row_width   <= 16'd1024;
      depth       <= '0;
      ncell       <= '0;
      k           <= '0;
      cptr        <= '0;
      out_valid   <= 1'b0;
      last_result <= 1'b0;
      l_skip      <= 1'b0;
      l_last      <= 1'b0;
    end else begin
      out_valid   <= cmd.emit;
      last_result <= cmd.emit && sts.k_last && sts.cell_last;
      cptr        <= cptr_next;
      if (cfg_we) row_width <= cfg_wdata;
      if (cmd.accept) begin
        l_skip <= skip_cell;
        l_last <= last_in_row;
      end
      if (cmd.row_clear) begin
        depth <= '0;
        ncell <= '0;
      end else if (cmd.push) begin
        depth <= depth + CW'(1);
        ncell <= ncell + CW'(1);
      end else if (cmd.merge) begin
        depth <= dm1;
      end
      if (cmd.k_clr) k <= '0;
      else if (cmd.k_inc) k <= k + CW'(1);
    end
  end

  // stacks and arithmetic
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      l_tag <= cell_tag;
      l_row <= row_index;
      l_tx  <= target_x;
      l_w   <= cell_width;
      l_pl  <= pad_left;
      l_pr  <= pad_right;
    end
    if (cmd.push) begin
      if (depth != '0) cmem[dm1[AW-1:0]] <= top;
      smem[ncell[AW-1:0]] <= '{tag: l_tag, pl: l_pl, eff: eff};
      top.q <= $signed(QW'(l_tx)) - $signed(QW'(l_pl));
      top.c <= CW'(1);
      top.w <= WW'(eff);
    end else if (cmd.merge) begin
      top.q <= rd.q + top.q;
      top.c <= rd.c + top.c;
      top.w <= rd.w + top.w;
    end
    if (cmd.rd_pv || cmd.rd_k) rd <= cmem[rd_addr];
    crd <= smem[cptr_next[AW-1:0]];
    if (cmd.opt_m) begin
      pn <= po.num;
      pd <= po.den;
      pw <= rd.w;
      ln <= lo.num;
      ld <= lo.den;
    end
    if (cmd.mul_m) begin
      lhs_a <= LW'(pn) + LW'(pw) * LW'(pd);
      rhs   <= (QW+CW)'(ln) * (QW+CW)'(pd);
    end
    if (cmd.e_ld) begin
      dvd  <= (DW'(eo.num) << 1) + DW'(eo.den);
      dvs  <= {eo.den, 1'b0};
      rem  <= '0;
      dcnt <= '0;
      e_hi <= eo.hi;
      crem <= ecl.c;
    end
    if (cmd.div_step) begin
      if (rsh >= {1'b0, dvs}) begin
        rem <= (CW+1)'(rsh - {1'b0, dvs});
        dvd <= {dvd[DW-2:0], 1'b1};
      end else begin
        rem <= rsh[CW:0];
        dvd <= {dvd[DW-2:0], 1'b0};
      end
      dcnt <= dcnt + NW'(1);
    end
    if (cmd.px_ld) begin
      if (e_hi < 0) px <= '0;
      else if (dvd > DW'(e_hi[WW-1:0])) px <= (WW+1)'(e_hi[WW-1:0]);
      else px <= dvd[WW:0];
    end
    if (cmd.emit) begin
      out_tag     <= crd.tag;
      out_row     <= l_row;
      placed_x    <= (xsum > (WW+2)'(16'hFFFF)) ? 16'hFFFF : xsum[WW-1:0];
      px          <= px + (WW+1)'(crd.eff);
      crem        <= crem - CW'(1);
    end
  end

endmodule

// File: rtl/abacus_row_cluster_legalizer_unit.sv
// ----------------------------------------------------------------------------
// abacus_row_cluster_legalizer_unit: one-row cluster legalizer
// pushes cells as clusters, merges overlapping clusters, emits placed x
// ----------------------------------------------------------------------------
//  channel   signals                                   handshake
//  config    cfg_we, cfg_wdata (row_width)             write when cfg_we
//  request   cell_tag .. last_in_row                   start && !busy
//  result    out_tag, out_row, placed_x, last_result   out_valid, one cycle
//
//  a pushed request holds busy for decode, push, stack read and finish, plus
//  optimum, multiply, compare and reread per merge, plus the final compare
//  when two or more clusters remain; a skipped one holds decode and finish
//  a row's last request adds, per cluster, stack read, divider load, 26
//  quotient bits one a cycle, clamp, an emit per cell; then a stack clear
//  reset empties the stack and sets row_width to 1024; no clearing pass
//  the receiver cannot stall: one result per out_valid pulse
module abacus_row_cluster_legalizer_unit import arcl_pkg::*; #(
  parameter int MAX_CELLS_PER_ROW = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic        cfg_we,
  input  logic [15:0] cfg_wdata,
  input  logic [15:0] cell_tag,
  input  logic [11:0] row_index,
  input  logic [15:0] target_x,
  input  logic [7:0]  cell_width,
  input  logic [5:0]  pad_left,
  input  logic [5:0]  pad_right,
  input  logic        skip_cell,
  input  logic        last_in_row,
  output logic        out_valid,
  output logic [15:0] out_tag,
  output logic [11:0] out_row,
  output logic [15:0] placed_x,
  output logic        last_result
);

  // commands from the sequencer, status back from the datapath
  cmd_t cmd;
  sts_t sts;

  arcl_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .sts   (sts),
    .cmd   (cmd)
  );

  arcl_dp #(
    .MAX_CELLS_PER_ROW (MAX_CELLS_PER_ROW)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .sts         (sts),
    .cfg_we      (cfg_we),
    .cfg_wdata   (cfg_wdata),
    .cell_tag    (cell_tag),
    .row_index   (row_index),
    .target_x    (target_x),
    .cell_width  (cell_width),
    .pad_left    (pad_left),
    .pad_right   (pad_right),
    .skip_cell   (skip_cell),
    .last_in_row (last_in_row),
    .out_valid   (out_valid),
    .out_tag     (out_tag),
    .out_row     (out_row),
    .placed_x    (placed_x),
    .last_result (last_result)
  );

  // results only appear while a row is being emitted
  a_res_busy: assert property (@(posedge clk) disable iff (rst) out_valid |-> busy)
    else $error("result outside of row emission");

  // end-of-row flag rides on a result
  a_last_valid: assert property (@(posedge clk) disable iff (rst)
    last_result |-> out_valid)
    else $error("last_result without result strobe");

  // nothing follows the row's final result
  a_last_end: assert property (@(posedge clk) disable iff (rst)
    (out_valid && last_result) |=> !out_valid)
    else $error("result after end of row");

  // an accepted request always starts the sequencer
  a_accept: assert property (@(posedge clk) disable iff (rst) (start && !busy) |=> busy)
    else $error("request accepted but block not busy");

endmodule
